@@ hdl/rpe_pkg.sv @@
// rpe_pkg: shared types, register codes and helpers for the relative permeability unit
// used by rpe_sqrt_pipe and relative_permeability_eval_unit; no dependencies
`default_nettype none
package rpe_pkg;

   localparam int unsigned FRAC_BITS    = 15;
   localparam int unsigned RECIP_BITS   = 16;
   localparam logic [10:0] MAX_GRID     = 11'd1024;
   localparam logic [15:0] ONE_Q        = 16'h8000;
   localparam int unsigned SQRT_STAGES  = 4;
   localparam int unsigned SQRT_PER_STG = 4;
   localparam int unsigned SQRT_W       = 31;

   typedef enum logic [2:0] {
      CSR_MODEL_SELECT  = 3'd0,
      CSR_CONNATE_WATER = 3'd1,
      CSR_RESIDUAL_OIL  = 3'd2,
      CSR_CRITICAL_GAS  = 3'd3,
      CSR_RECIP_SPAN    = 3'd4,
      CSR_GRID_X        = 3'd5,
      CSR_GRID_Y        = 3'd6,
      CSR_GRID_Z        = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      MODEL_COREY = 2'd0,
      MODEL_NAAR  = 2'd1,
      MODEL_WYGAL = 2'd2
   } model_type;

   typedef struct packed {
      logic [9:0]  cell_x;
      logic [9:0]  cell_y;
      logic [9:0]  cell_z;
      logic        fluid_cell;
      logic [15:0] sat_water;
      logic [15:0] sat_oil;
      logic [15:0] sat_gas;
   } req_type;

   typedef struct packed {
      logic        updated;
      logic [15:0] perm_oil;
      logic [15:0] perm_water;
      logic [15:0] perm_gas;
      logic        gas_valid;
   } rsp_type;

   // control and finished results travelling down the pipeline
   typedef struct packed {
      logic        valid;
      logic        upd;
      logic [1:0]  model;
      logic        oil_cut;
      logic        gas_cut;
      logic [15:0] krw;
      logic [15:0] kro_corey;
      logic [15:0] kro_wygal;
      logic [15:0] krg;
   } ctl_type;

   typedef struct packed {
      logic [SQRT_W-1:0] rem;
      logic [SQRT_W-1:0] res;
   } sqrt_state_type;

   function automatic logic [15:0] sat_one(input logic [48:0] v);
      return (v > 49'(ONE_Q)) ? ONE_Q : v[15:0];
   endfunction

   function automatic logic on_edge(input logic [9:0] c, input logic [10:0] size);
      logic [10:0] sz;
      sz = (size > MAX_GRID) ? MAX_GRID : size;
      return (c == 10'd0) || (sz == 11'd0) || ((11'(c) + 11'd1) >= sz);
   endfunction

   // one digit of the restoring square root, step k of sixteen
   function automatic sqrt_state_type sqrt_step(input sqrt_state_type st,
                                                input int unsigned k);
      logic [SQRT_W-1:0] bitv;
      logic [SQRT_W-1:0] trial;
      sqrt_state_type    nx;
      bitv  = SQRT_W'(1) << (SQRT_W - 1 - 2 * k);
      trial = st.res + bitv;
      if (st.rem >= trial) begin
         nx.rem = st.rem - trial;
         nx.res = (st.res >> 1) + bitv;
      end else begin
         nx.rem = st.rem;
         nx.res = st.res >> 1;
      end
      return nx;
   endfunction

endpackage
`default_nettype wire

@@ hdl/rpe_sqrt_pipe.sv @@
// rpe_sqrt_pipe: pipelined floor square root of b << 15, four digits per stage
// depends on rpe_pkg
`default_nettype none
module rpe_sqrt_pipe (
   input  wire logic        clock,
   input  wire logic [15:0] base,
   output logic      [15:0] root
);
   import rpe_pkg::*;

   sqrt_state_type stage_ff [SQRT_STAGES];
   sqrt_state_type stage_in [SQRT_STAGES];

   always_comb begin
      sqrt_state_type st;
      for (int s = 0; s < SQRT_STAGES; s++) begin
         if (s == 0) begin
            st.rem = SQRT_W'(base) << FRAC_BITS;
            st.res = '0;
         end else begin
            st = stage_ff[s-1];
         end
         for (int j = 0; j < SQRT_PER_STG; j++) begin
            st = sqrt_step(st, s * SQRT_PER_STG + j);
         end
         stage_in[s] = st;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
   end

   assign root = stage_ff[SQRT_STAGES-1].res[15:0];

endmodule
`default_nettype wire

@@ hdl/relative_permeability_eval_unit.sv @@
// relative_permeability_eval_unit: corey, naar and wygal relative permeability per grid cell
// depends on rpe_pkg and rpe_sqrt_pipe
// a result passes through ctl_ff[1..8] and a final output register before showing on rsp_*
// throughput: one request per clock, busy stays low; the naar square root pipeline sets depth
// reset: synchronous, clears pipeline valids and loads register defaults
`default_nettype none
module relative_permeability_eval_unit (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire rpe_pkg::req_type       req_data,
   output logic                        rsp_valid,
   output rpe_pkg::rsp_type            rsp_data,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire rpe_pkg::csr_index_type csr_index,
   input  wire logic [18:0]            csr_wdata
);
   import rpe_pkg::*;

   // configuration registers
   logic [1:0]  model_ff;
   logic [14:0] swc_ff;
   logic [15:0] sor_ff;
   logic [15:0] sgc_ff;
   logic [18:0] recip_ff;
   logic [10:0] gx_ff, gy_ff, gz_ff;

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         model_ff <= 2'd0;
         swc_ff   <= '0;
         sor_ff   <= '0;
         sgc_ff   <= '0;
         recip_ff <= 19'd65536;
         gx_ff    <= MAX_GRID;
         gy_ff    <= MAX_GRID;
         gz_ff    <= MAX_GRID;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MODEL_SELECT:  model_ff <= csr_wdata[1:0];
            CSR_CONNATE_WATER: swc_ff   <= csr_wdata[14:0];
            CSR_RESIDUAL_OIL:  sor_ff   <= csr_wdata[15:0];
            CSR_CRITICAL_GAS:  sgc_ff   <= csr_wdata[15:0];
            CSR_RECIP_SPAN:    recip_ff <= csr_wdata;
            CSR_GRID_X:        gx_ff    <= csr_wdata[10:0];
            CSR_GRID_Y:        gy_ff    <= csr_wdata[10:0];
            CSR_GRID_Z:        gz_ff    <= csr_wdata[10:0];
         endcase
      end
   end

   // control travels in ctl_ff[1..8], one entry per stage
   ctl_type ctl_ff [1:8];
   ctl_type ctl_in [1:8];

   // stage 1: products straight off the request
   logic [34:0] p1_ff,  p1_in;     // (sw - swc) * recip
   logic [31:0] so2_ff, so2_in;    // so^2
   logic [31:0] sg2_ff, sg2_in;    // sg^2
   logic [37:0] rr_ff,  rr_in;     // recip^2
   logic [17:0] fo1_ff, fo1_in;    // wygal oil bracket
   logic [16:0] fg1_ff, fg1_in;    // wygal gas bracket
   logic [15:0] so1_ff, so1_in;
   logic [15:0] sg1_ff, sg1_in;
   // stage 2
   logic [15:0] s2_ff,  s2_in;     // normalised saturation
   logic [15:0] ss2_ff, ss2_in;    // s^2
   logic [17:0] co2_ff, co2_in;    // so^3
   logic [17:0] cg2_ff, cg2_in;    // sg^3
   logic [27:0] r42_ff, r42_in;    // 1/(1-swc)^4, q.16
   logic [17:0] fo2_ff, fo2_in;
   logic [16:0] fg2_ff, fg2_in;
   // stage 3
   logic [15:0] tt3_ff, tt3_in;    // (1-s)^2
   logic [15:0] om3_ff, om3_in;    // 1-s^2
   logic [15:0] b3_ff,  b3_in;     // naar base
   logic [20:0] cof3_ff, cof3_in;
   logic [19:0] cgf3_ff, cgf3_in;
   logic [27:0] r43_ff, r43_in;
   // naar base delayed alongside the root pipeline
   logic [15:0] bd_ff [4:7];
   logic [15:0] root;
   // stage 8
   logic [15:0] br8_ff, br8_in;
   logic [16:0] f8_ff,  f8_in;
   // output
   logic    rsp_valid_ff;
   rsp_type rsp_ff, rsp_in;

   rpe_sqrt_pipe u_sqrt (
      .clock (clock),
      .base  (b3_ff),
      .root  (root)
   );

   always_comb begin
      logic        edge_hit;
      logic [15:0] d;
      logic [18:0] sraw;
      logic [15:0] s;
      logic [31:0] sq;
      logic [32:0] co_p;
      logic [32:0] cg_p;
      logic [21:0] r2;
      logic [43:0] r4_p;
      logic signed [19:0] fo_s;
      logic signed [18:0] fg_s;
      logic [16:0] t;
      logic [33:0] tt_p;
      logic [16:0] two_s;
      logic [35:0] cof_p;
      logic [34:0] cgf_p;
      logic [31:0] krw_p;
      logic [31:0] kroc_p;
      logic [48:0] krow_p;
      logic [47:0] krg_p;
      logic [31:0] br_p;
      logic [32:0] kron_p;

      // stage 1
      edge_hit = on_edge(req_data.cell_x, gx_ff) || on_edge(req_data.cell_y, gy_ff) ||
                 on_edge(req_data.cell_z, gz_ff);
      ctl_in[1]           = '0;
      ctl_in[1].valid     = start && !busy;
      ctl_in[1].upd       = !edge_hit && req_data.fluid_cell && (model_ff != 2'd3);
      ctl_in[1].model     = model_ff;
      ctl_in[1].oil_cut   = req_data.sat_oil <= sor_ff;
      ctl_in[1].gas_cut   = req_data.sat_gas <= sgc_ff;
      d = (req_data.sat_water > 16'(swc_ff)) ? req_data.sat_water - 16'(swc_ff) : 16'd0;
      p1_in  = 35'(d) * 35'(recip_ff);
      so2_in = 32'(req_data.sat_oil) * 32'(req_data.sat_oil);
      sg2_in = 32'(req_data.sat_gas) * 32'(req_data.sat_gas);
      rr_in  = 38'(recip_ff) * 38'(recip_ff);
      fo_s   = 20'sd32768 - 20'(req_data.sat_gas) + (20'(req_data.sat_water) << 1)
               - 20'(swc_ff) * 20'sd3;
      fg_s   = 19'sd65536 - 19'(req_data.sat_gas) - (19'(swc_ff) << 1);
      fo1_in = fo_s[19] ? 18'd0 : fo_s[17:0];
      fg1_in = fg_s[18] ? 17'd0 : fg_s[16:0];
      so1_in = req_data.sat_oil;
      sg1_in = req_data.sat_gas;

      for (int k = 2; k <= 8; k++) begin
         ctl_in[k] = ctl_ff[k-1];
      end

      // stage 2: normalised saturation and cubes
      sraw   = p1_ff[34:RECIP_BITS];
      s      = (sraw > 19'(ONE_Q)) ? ONE_Q : sraw[15:0];
      s2_in  = s;
      sq     = 32'(s) * 32'(s);
      ss2_in = sq[30:FRAC_BITS];
      co_p   = 33'(so2_ff[31:FRAC_BITS]) * 33'(so1_ff);
      cg_p   = 33'(sg2_ff[31:FRAC_BITS]) * 33'(sg1_ff);
      co2_in = co_p[32:FRAC_BITS];
      cg2_in = cg_p[32:FRAC_BITS];
      r2     = rr_ff[37:RECIP_BITS];
      r4_p   = 44'(r2) * 44'(r2);
      r42_in = r4_p[43:RECIP_BITS];
      fo2_in = fo1_ff;
      fg2_in = fg1_ff;

      // stage 3: water curve, corey factors, naar base, wygal brackets
      krw_p         = 32'(ss2_ff) * 32'(ss2_ff);
      ctl_in[3].krw = sat_one(49'(krw_p >> FRAC_BITS));
      t       = 17'(ONE_Q) - 17'(s2_ff);
      tt_p    = 34'(t) * 34'(t);
      tt3_in  = 16'(tt_p >> FRAC_BITS);
      om3_in  = 16'(17'(ONE_Q) - 17'(ss2_ff));
      two_s   = 17'(s2_ff) << 1;
      b3_in   = (two_s >= 17'(ONE_Q)) ? 16'd0 : 16'(17'(ONE_Q) - two_s);
      cof_p   = 36'(co2_ff) * 36'(fo2_ff);
      cgf_p   = 35'(cg2_ff) * 35'(fg2_ff);
      cof3_in = 21'(cof_p >> FRAC_BITS);
      cgf3_in = 20'(cgf_p >> FRAC_BITS);
      r43_in  = r42_ff;

      // stage 4: corey and wygal oil, wygal gas
      kroc_p               = 32'(tt3_ff) * 32'(om3_ff);
      ctl_in[4].kro_corey  = sat_one(49'(kroc_p >> FRAC_BITS));
      krow_p               = 49'(cof3_ff) * 49'(r43_ff);
      krg_p                = 48'(cgf3_ff) * 48'(r43_ff);
      ctl_in[4].kro_wygal  = ctl_ff[3].oil_cut ? 16'd0 : sat_one(krow_p >> RECIP_BITS);
      ctl_in[4].krg        = ctl_ff[3].gas_cut ? 16'd0 : sat_one(49'(krg_p >> RECIP_BITS));

      // stage 8: naar b*r and 2-r
      br_p   = 32'(bd_ff[7]) * 32'(root);
      br8_in = 16'(br_p >> FRAC_BITS);
      f8_in  = 17'(18'd65536 - 18'(root));

      // output: naar finish and model select
      kron_p = 33'(br8_ff) * 33'(f8_ff);
      rsp_in = '0;
      if (ctl_ff[8].upd) begin
         rsp_in.updated    = 1'b1;
         rsp_in.perm_water = ctl_ff[8].krw;
         unique case (ctl_ff[8].model)
            MODEL_COREY: rsp_in.perm_oil = ctl_ff[8].kro_corey;
            MODEL_NAAR:  rsp_in.perm_oil = sat_one(49'(kron_p >> FRAC_BITS));
            MODEL_WYGAL: begin
               rsp_in.perm_oil  = ctl_ff[8].kro_wygal;
               rsp_in.perm_gas  = ctl_ff[8].krg;
               rsp_in.gas_valid = 1'b1;
            end
            default: rsp_in.perm_oil = 16'd0;
         endcase
      end
   end

   // control and result strobe, cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 1; k <= 8; k++) begin
            ctl_ff[k] <= '0;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         ctl_ff       <= ctl_in;
         rsp_valid_ff <= ctl_ff[8].valid;
      end
   end

   always_ff @(posedge clock) begin
      p1_ff   <= p1_in;
      so2_ff  <= so2_in;
      sg2_ff  <= sg2_in;
      rr_ff   <= rr_in;
      fo1_ff  <= fo1_in;
      fg1_ff  <= fg1_in;
      so1_ff  <= so1_in;
      sg1_ff  <= sg1_in;
      s2_ff   <= s2_in;
      ss2_ff  <= ss2_in;
      co2_ff  <= co2_in;
      cg2_ff  <= cg2_in;
      r42_ff  <= r42_in;
      fo2_ff  <= fo2_in;
      fg2_ff  <= fg2_in;
      tt3_ff  <= tt3_in;
      om3_ff  <= om3_in;
      b3_ff   <= b3_in;
      cof3_ff <= cof3_in;
      cgf3_ff <= cgf3_in;
      r43_ff  <= r43_in;
      bd_ff[4] <= b3_ff;
      for (int k = 5; k <= 7; k++) begin
         bd_ff[k] <= bd_ff[k-1];
      end
      br8_ff  <= br8_in;
      f8_ff   <= f8_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   // every result traces back to an earlier start request
   a_rsp_has_request: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, 9))
      else $error("result without a matching request");

   a_gas_needs_update: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.gas_valid |-> rsp_data.updated)
      else $error("gas permeability flagged on a skipped cell");

   a_skipped_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.updated |->
         (rsp_data.perm_oil == 16'd0) && (rsp_data.perm_water == 16'd0) &&
         (rsp_data.perm_gas == 16'd0))
      else $error("skipped cell carries non-zero permeability");

   a_saturated: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.perm_oil <= ONE_Q) && (rsp_data.perm_water <= ONE_Q) &&
                    (rsp_data.perm_gas <= ONE_Q))
      else $error("permeability above one");
`endif

endmodule
`default_nettype wire
